// ===== hw/rtl/digit_matrix_permute_engine_core_macros.svh =====
// assertion macros for the digit matrix permute engine rtl
`ifndef DIGIT_MATRIX_PERMUTE_ENGINE_CORE_MACROS_SVH
`define DIGIT_MATRIX_PERMUTE_ENGINE_CORE_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define DMPE_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dmpe assertion failed");

// next-cycle implication, checked on clk, off during rst
`define DMPE_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dmpe assertion failed");

`endif

// ===== hw/rtl/dmpe_pkg.sv =====
// shared widths, opcodes and controller/datapath types for the permute engine
package dmpe_pkg;

  localparam int OP_W         = 3;
  localparam int IDX_FIELD_W  = 4;
  localparam int DIGIT_W      = 4;
  localparam int SIDE_W       = 5;
  localparam int DEF_MAX_SIDE = 16;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W:0]   RADIX     = 5'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;

  localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
  localparam logic [OP_W-1:0] OP_READ      = 3'd1;
  localparam logic [OP_W-1:0] OP_SWAP_ROW  = 3'd2;
  localparam logic [OP_W-1:0] OP_SWAP_COL  = 3'd3;
  localparam logic [OP_W-1:0] OP_INC       = 3'd4;
  localparam logic [OP_W-1:0] OP_DEC       = 3'd5;
  localparam logic [OP_W-1:0] OP_TRANSPOSE = 3'd6;

  typedef struct packed {
    logic accept;    // take the request beat
    logic exec;      // store access or first map write
    logic swap2;     // second map write of a swap
    logic load_out;  // load the result register
  } dmpe_cmd_t;

  typedef struct packed {
    logic needs_map; // request beat is an in-range write, read or swap
    logic is_write;
    logic is_read;
    logic is_swap;
  } dmpe_sts_t;

endpackage

// ===== hw/rtl/dmpe_req_if.sv =====
// request channel: one operation per beat
interface dmpe_req_if;
  import dmpe_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        opcode;
  logic [IDX_FIELD_W-1:0] first_index;
  logic [IDX_FIELD_W-1:0] second_index;
  logic [DIGIT_W-1:0]     digit_in;

  modport source (output valid, output opcode, output first_index, output second_index,
                  output digit_in, input ready);
  modport sink (input valid, input opcode, input first_index, input second_index,
                input digit_in, output ready);
endinterface

// ===== hw/rtl/dmpe_rsp_if.sv =====
// response channel: one read result per beat
interface dmpe_rsp_if;
  import dmpe_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [DIGIT_W-1:0]     digit_out;
  logic [IDX_FIELD_W-1:0] row_echo;
  logic [IDX_FIELD_W-1:0] col_echo;

  modport source (output valid, output digit_out, output row_echo, output col_echo,
                  input ready);
  modport sink (input valid, input digit_out, input row_echo, input col_echo,
                output ready);
endinterface

// ===== hw/rtl/dmpe_cfg_if.sv =====
// configuration write channel for the matrix side register
interface dmpe_cfg_if;
  import dmpe_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIDE_W-1:0] matrix_side;

  modport source (output valid, output matrix_side, input ready);
  modport sink (input valid, input matrix_side, output ready);
endinterface

// ===== hw/rtl/digit_matrix_permute_engine_core.sv =====
// Digit matrix permute engine: a square matrix of decimal digits (side 1..MAX_SIDE,
// set through cfg) reached through a row map, a column map, a transpose flag and a
// digit offset, so no operation walks the cells. One request beat is one operation.
// Increment, decrement, transpose, opcode 7 and out-of-range operations end in IDLE;
// an in-range write also passes LOOK and EXEC, and an in-range read or swap then RESP
// or SWAP, a read staying in RESP while an earlier result still waits on rsp. These
// states follow from the registered read of the map memories and their single write
// port, which a swap uses twice. Only an in-range read returns a beat on rsp; one
// finished result waits in the output register while the next request is taken. The
// cell store has no reset: a read of a cell never written returns an arbitrary digit.
module digit_matrix_permute_engine_core #(
  parameter int MAX_SIDE = dmpe_pkg::DEF_MAX_SIDE
) (
  input logic       clk,
  input logic       rst,
  dmpe_req_if.sink   req,
  dmpe_rsp_if.source rsp,
  dmpe_cfg_if.sink   cfg
);
  import dmpe_pkg::*;

  dmpe_cmd_t cmd;
  dmpe_sts_t sts;

  assign cfg.ready = 1'b1;

  dmpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dmpe_datapath #(.MAX_SIDE(MAX_SIDE)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_opcode(req.opcode),
    .req_first (req.first_index),
    .req_second(req.second_index),
    .req_digit (req.digit_in),
    .cfg_write (cfg.valid),
    .cfg_side  (cfg.matrix_side),
    .cmd       (cmd),
    .sts       (sts),
    .digit_out (rsp.digit_out),
    .row_echo  (rsp.row_echo),
    .col_echo  (rsp.col_echo)
  );
endmodule

// ===== hw/rtl/dmpe_map_ram.sv =====
// index map memory, two registered read ports, identity until an entry is written
module dmpe_map_ram #(
  parameter int DEPTH = dmpe_pkg::DEF_MAX_SIDE,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd0_addr,
  input  logic [IDX_W-1:0] rd1_addr,
  output logic [IDX_W-1:0] rd0_data,
  output logic [IDX_W-1:0] rd1_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] wr_data
);
  logic [IDX_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [IDX_W-1:0] rd0_q, rd1_q, rd0_addr_q, rd1_addr_q;
  logic             rd0_vld, rd1_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0_q      <= mem[rd0_addr];
    rd1_q      <= mem[rd1_addr];
    rd0_addr_q <= rd0_addr;
    rd1_addr_q <= rd1_addr;
    rd0_vld    <= written[rd0_addr];
    rd1_vld    <= written[rd1_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // unwritten entries read back as their own index
  assign rd0_data = rd0_vld ? rd0_q : rd0_addr_q;
  assign rd1_data = rd1_vld ? rd1_q : rd1_addr_q;
endmodule

// ===== hw/rtl/dmpe_datapath.sv =====
// item registers, remap state, cell store and result register
module dmpe_datapath #(
  parameter int MAX_SIDE = dmpe_pkg::DEF_MAX_SIDE
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [dmpe_pkg::OP_W-1:0]        req_opcode,
  input  logic [dmpe_pkg::IDX_FIELD_W-1:0] req_first,
  input  logic [dmpe_pkg::IDX_FIELD_W-1:0] req_second,
  input  logic [dmpe_pkg::DIGIT_W-1:0]     req_digit,
  input  logic                             cfg_write,
  input  logic [dmpe_pkg::SIDE_W-1:0]      cfg_side,
  input  dmpe_pkg::dmpe_cmd_t              cmd,
  output dmpe_pkg::dmpe_sts_t              sts,
  output logic [dmpe_pkg::DIGIT_W-1:0]     digit_out,
  output logic [dmpe_pkg::IDX_FIELD_W-1:0] row_echo,
  output logic [dmpe_pkg::IDX_FIELD_W-1:0] col_echo
);
  import dmpe_pkg::*;

  localparam int IDX_W  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int ADDR_W = 2 * IDX_W;

  logic [SIDE_W-1:0]      side;
  logic                   flag;
  logic [DIGIT_W-1:0]     offset;
  logic [OP_W-1:0]        op_q;
  logic [IDX_FIELD_W-1:0] i_q, j_q;
  logic [DIGIT_W-1:0]     d_q;

  logic                   req_ok;
  logic [IDX_W-1:0]       ai, aj;
  logic [IDX_W-1:0]       row_rd0, row_rd1, col_rd0, col_rd1, pr, pc;
  logic                   row_sel, map_we, row_we, col_we;
  logic [IDX_W-1:0]       row_wa, row_wd, col_wa, col_wd;
  logic [ADDR_W-1:0]      store_addr;
  logic [DIGIT_W-1:0]     store [2**ADDR_W];
  logic [DIGIT_W-1:0]     store_q;
  logic [DIGIT_W-1:0]     d_sat, enc;
  logic [DIGIT_W:0]       enc_sum, dec_sum;
  logic [DIGIT_W-1:0]     dec;

  // side register with clamping into 1..MAX_SIDE
  always_ff @(posedge clk) begin
    if (rst) begin
      side <= SIDE_W'(1);
    end else if (cfg_write) begin
      priority if (cfg_side == '0) begin
        side <= SIDE_W'(1);
      end else if (int'(cfg_side) > MAX_SIDE) begin
        side <= SIDE_W'(MAX_SIDE);
      end else begin
        side <= cfg_side;
      end
    end
  end

  assign req_ok = ({1'b0, req_first} < side) && ({1'b0, req_second} < side);

  // transpose and digit offset change in the accept cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      flag   <= 1'b0;
      offset <= DIGIT_ZERO;
    end else if (cmd.accept) begin
      if (req_opcode == OP_TRANSPOSE) begin
        flag <= ~flag;
      end
      if (req_opcode == OP_INC) begin
        offset <= (offset == DIGIT_MAX) ? DIGIT_ZERO : offset + 4'd1;
      end else if (req_opcode == OP_DEC) begin
        offset <= (offset == DIGIT_ZERO) ? DIGIT_MAX : offset - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q <= req_opcode;
      i_q  <= req_first;
      j_q  <= req_second;
      d_q  <= req_digit;
    end
  end

  assign sts.needs_map = req_ok && ((req_opcode == OP_WRITE) || (req_opcode == OP_READ) ||
                                    (req_opcode == OP_SWAP_ROW) || (req_opcode == OP_SWAP_COL));
  assign sts.is_write  = (op_q == OP_WRITE);
  assign sts.is_read   = (op_q == OP_READ);
  assign sts.is_swap   = (op_q == OP_SWAP_ROW) || (op_q == OP_SWAP_COL);

  assign ai = IDX_W'(i_q);
  assign aj = IDX_W'(j_q);

  // a swap writes map[i] from old map[j], then map[j] from old map[i]
  assign row_sel = (op_q == OP_SWAP_ROW) ^ flag;
  assign map_we  = (cmd.exec || cmd.swap2) && sts.is_swap;
  assign row_we  = map_we && row_sel;
  assign col_we  = map_we && !row_sel;
  assign row_wa  = cmd.swap2 ? aj : ai;
  assign row_wd  = cmd.swap2 ? row_rd0 : row_rd1;
  assign col_wa  = cmd.swap2 ? aj : ai;
  assign col_wd  = cmd.swap2 ? col_rd0 : col_rd1;

  dmpe_map_ram #(.DEPTH(MAX_SIDE), .IDX_W(IDX_W)) u_row_map (
    .clk     (clk),
    .rst     (rst),
    .rd0_addr(ai),
    .rd1_addr(aj),
    .rd0_data(row_rd0),
    .rd1_data(row_rd1),
    .wr_en   (row_we),
    .wr_addr (row_wa),
    .wr_data (row_wd)
  );

  dmpe_map_ram #(.DEPTH(MAX_SIDE), .IDX_W(IDX_W)) u_col_map (
    .clk     (clk),
    .rst     (rst),
    .rd0_addr(ai),
    .rd1_addr(aj),
    .rd0_data(col_rd0),
    .rd1_data(col_rd1),
    .wr_en   (col_we),
    .wr_addr (col_wa),
    .wr_data (col_wd)
  );

  // transposed access swaps which logical index feeds each map
  assign pr         = flag ? row_rd1 : row_rd0;
  assign pc         = flag ? col_rd0 : col_rd1;
  assign store_addr = {pr, pc};

  // stored digit is the logical digit minus the offset, mod 10
  assign d_sat   = (d_q > DIGIT_MAX) ? DIGIT_MAX : d_q;
  assign enc_sum = {1'b0, d_sat} + RADIX - {1'b0, offset};
  assign enc     = (enc_sum >= RADIX) ? DIGIT_W'(enc_sum - RADIX) : enc_sum[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.exec && sts.is_write) begin
      store[store_addr] <= enc;
    end
    store_q <= store[store_addr];
  end

  assign dec_sum = {1'b0, store_q} + {1'b0, offset};
  assign dec     = (dec_sum >= RADIX) ? DIGIT_W'(dec_sum - RADIX) : dec_sum[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      digit_out <= dec;
      row_echo  <= i_q;
      col_echo  <= j_q;
    end
  end
endmodule

// ===== hw/rtl/dmpe_ctrl.sv =====
// sequencing state machine and result valid for the permute engine
`include "digit_matrix_permute_engine_core_macros.svh"
module dmpe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dmpe_pkg::dmpe_sts_t sts,
  output dmpe_pkg::dmpe_cmd_t cmd
);
  import dmpe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_EXEC = 5'b00100,
    S_SWAP = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.exec     = 1'b0;
    cmd.swap2    = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = req_valid;
        if (req_valid && sts.needs_map) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (sts.is_read) begin
          state_next = S_RESP;
        end else if (sts.is_swap) begin
          state_next = S_SWAP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SWAP: begin
        cmd.swap2  = 1'b1;
        state_next = S_IDLE;
      end
      S_RESP: begin
        // hold the store read until the result register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DMPE_ASSERT_IMPL(a_look_after_accept, state == S_LOOK, $past(state == S_IDLE && req_valid))
  `DMPE_ASSERT_IMPL(a_swap_after_exec, state == S_SWAP, $past(state == S_EXEC))
  `DMPE_ASSERT_IMPL(a_result_from_resp, $rose(out_valid), $past(state == S_RESP))
  `DMPE_ASSERT_NEXT(a_resp_leaves_when_free, state == S_RESP && out_free, state == S_IDLE)
endmodule

// ===== dv/digit_matrix_permute_engine_core_check.sv =====
// watches the permute engine channels, predicts each read and compares the results
module digit_matrix_permute_engine_core_check (
  input  logic       clk,
  input  logic       rst,
  dmpe_req_if        req,
  dmpe_rsp_if        rsp,
  dmpe_cfg_if        cfg,
  output int         mismatches,
  output int         pending,
  output int         compared
);
  import dmpe_pkg::*;

  localparam int SIDE_MAX = DEF_MAX_SIDE;

  typedef struct packed {
    logic [DIGIT_W-1:0]     digit;
    logic [IDX_FIELD_W-1:0] row;
    logic [IDX_FIELD_W-1:0] col;
  } read_result_t;

  // physical digits are held minus the running offset, mod ten
  logic [DIGIT_W-1:0]     cells [SIDE_MAX*SIDE_MAX];
  logic [IDX_FIELD_W-1:0] row_perm [SIDE_MAX];
  logic [IDX_FIELD_W-1:0] col_perm [SIDE_MAX];
  logic                   flipped;
  logic [DIGIT_W-1:0]     offset;
  logic [SIDE_W-1:0]      side;

  read_result_t expected_reads[$];
  read_result_t want;
  read_result_t got;
  logic [IDX_FIELD_W-1:0] tmp;
  int                     addr;
  int                     wdigit;
  logic                   in_range;

  function automatic int cell_addr(input logic [IDX_FIELD_W-1:0] r,
                                   input logic [IDX_FIELD_W-1:0] c);
    logic [IDX_FIELD_W-1:0] a;
    logic [IDX_FIELD_W-1:0] b;
    a = flipped ? c : r;
    b = flipped ? r : c;
    return int'(row_perm[a]) * SIDE_MAX + int'(col_perm[b]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SIDE_MAX; k++) begin
        row_perm[k] = k[IDX_FIELD_W-1:0];
        col_perm[k] = k[IDX_FIELD_W-1:0];
      end
      flipped = 1'b0;
      offset  = DIGIT_ZERO;
      side    = 5'd1;
      expected_reads.delete();
      mismatches <= 0;
      compared   <= 0;
      pending    <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.matrix_side == 0)
          side = 5'd1;
        else if (cfg.matrix_side > SIDE_MAX)
          side = SIDE_MAX[SIDE_W-1:0];
        else
          side = cfg.matrix_side;
      end

      // retire results before taking this edge's request
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.digit_out, rsp.row_echo, rsp.col_echo};
        if (expected_reads.size() == 0) begin
          $display("%0t: unexpected result digit %0d row %0d col %0d",
                   $time, got.digit, got.row, got.col);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_reads.pop_front();
          compared <= compared + 1;
          if (got !== want) begin
            $display("%0t: read mismatch expected digit %0d row %0d col %0d,",
                     $time, want.digit, want.row, want.col);
            $display("    got digit %0d row %0d col %0d", got.digit, got.row, got.col);
            mismatches <= mismatches + 1;
          end
        end
      end

      if (req.valid && req.ready) begin
        in_range = (req.first_index < side) && (req.second_index < side);
        case (req.opcode)
          OP_WRITE: begin
            if (in_range) begin
              wdigit = (req.digit_in > DIGIT_MAX) ? int'(DIGIT_MAX) : int'(req.digit_in);
              addr = cell_addr(req.first_index, req.second_index);
              cells[addr] = DIGIT_W'((wdigit + int'(RADIX) - int'(offset)) % int'(RADIX));
            end
          end
          OP_READ: begin
            if (in_range) begin
              addr = cell_addr(req.first_index, req.second_index);
              want.digit = DIGIT_W'((int'(cells[addr]) + int'(offset)) % int'(RADIX));
              want.row   = req.first_index;
              want.col   = req.second_index;
              expected_reads = {expected_reads, want};
            end
          end
          OP_SWAP_ROW, OP_SWAP_COL: begin
            // under transpose a logical row swap moves the column map
            if (in_range) begin
              if ((req.opcode == OP_SWAP_ROW) != flipped) begin
                tmp = row_perm[req.first_index];
                row_perm[req.first_index] = row_perm[req.second_index];
                row_perm[req.second_index] = tmp;
              end else begin
                tmp = col_perm[req.first_index];
                col_perm[req.first_index] = col_perm[req.second_index];
                col_perm[req.second_index] = tmp;
              end
            end
          end
          OP_INC: offset = DIGIT_W'((int'(offset) + 1) % int'(RADIX));
          OP_DEC: offset = DIGIT_W'((int'(offset) + int'(RADIX) - 1) % int'(RADIX));
          OP_TRANSPOSE: flipped = ~flipped;
          default: ;
        endcase
      end
      pending <= expected_reads.size();
    end
  end

endmodule

// ===== dv/digit_matrix_permute_engine_core_test.sv =====
// testbench top: drives the permute engine with operations and side settings
module digit_matrix_permute_engine_core_test;
  import dmpe_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PER_PHASE = 210;

  logic clk;
  logic rst;
  logic burst;
  int   mismatches;
  int   pending;
  int   compared;
  int   ops_sent;
  int   side_now;
  int   phases;
  int   quiet;

  dmpe_req_if req_ch ();
  dmpe_rsp_if rsp_ch ();
  dmpe_cfg_if cfg_ch ();

  digit_matrix_permute_engine_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  digit_matrix_permute_engine_core_check i_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one beat per call; valid stays high into the next call unless a gap is drawn
  task automatic issue_op(input logic [OP_W-1:0] op, input int a, input int b, input int d);
    int gap;
    if (ops_sent % 50 == 0) burst = ($urandom_range(0, 2) == 0);
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.first_index  <= a[IDX_FIELD_W-1:0];
    req_ch.second_index <= b[IDX_FIELD_W-1:0];
    req_ch.digit_in     <= d[DIGIT_W-1:0];
    do @(posedge clk); while (!req_ch.ready);
    ops_sent++;
  endtask

  // drain the engine, then write the side register
  task automatic set_side(input int v);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.matrix_side <= v[SIDE_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    side_now = (v == 0) ? 1 : (v > DEF_MAX_SIDE) ? DEF_MAX_SIDE : v;
    phases++;
  endtask

  function automatic int pick_index();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, side_now - 1);
  endfunction

  task automatic random_op();
    int r;
    logic [OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 25)      op = OP_WRITE;
    else if (r < 60) op = OP_READ;
    else if (r < 70) op = OP_SWAP_ROW;
    else if (r < 80) op = OP_SWAP_COL;
    else if (r < 85) op = OP_INC;
    else if (r < 90) op = OP_DEC;
    else if (r < 95) op = OP_TRANSPOSE;
    else             op = OP_UNUSED;
    issue_op(op, pick_index(), pick_index(), $urandom_range(0, 15));
  endtask

  // response side draws a stall before each beat
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("[digit_matrix_permute_engine_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int side_plan[$];
    ops_sent = 0;
    phases   = 0;
    side_now = 1;
    burst    = 1'b0;
    quiet    = 0;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.opcode       <= OP_WRITE;
    req_ch.first_index  <= '0;
    req_ch.second_index <= '0;
    req_ch.digit_in     <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.matrix_side  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fill the whole store while the maps are identity, so no read hits an unwritten cell
    set_side(DEF_MAX_SIDE);
    for (int r = 0; r < DEF_MAX_SIDE; r++)
      for (int c = 0; c < DEF_MAX_SIDE; c++)
        issue_op(OP_WRITE, r, c, $urandom_range(0, 15));

    // corners, saturation, swaps, offset wrap and transpose
    issue_op(OP_WRITE, 0, 0, 0);
    issue_op(OP_WRITE, 15, 15, 15);
    issue_op(OP_WRITE, 0, 15, 10);
    issue_op(OP_WRITE, 15, 0, 9);
    issue_op(OP_READ, 0, 0, 15);
    issue_op(OP_READ, 15, 15, 0);
    issue_op(OP_READ, 0, 15, 5);
    issue_op(OP_SWAP_ROW, 0, 15, 0);
    issue_op(OP_SWAP_ROW, 3, 3, 0);
    issue_op(OP_SWAP_COL, 0, 15, 0);
    issue_op(OP_READ, 15, 15, 0);
    issue_op(OP_INC, 0, 0, 0);
    issue_op(OP_READ, 0, 0, 0);
    issue_op(OP_DEC, 0, 0, 0);
    issue_op(OP_DEC, 0, 0, 0);
    issue_op(OP_READ, 15, 0, 0);
    issue_op(OP_TRANSPOSE, 0, 0, 0);
    issue_op(OP_READ, 0, 15, 0);
    issue_op(OP_SWAP_ROW, 1, 2, 0);
    issue_op(OP_SWAP_COL, 4, 5, 0);
    issue_op(OP_READ, 2, 4, 0);
    issue_op(OP_UNUSED, 15, 15, 15);
    issue_op(OP_TRANSPOSE, 0, 0, 0);
    issue_op(OP_READ, 0, 0, 0);

    for (int k = 0; k < RANDOM_PER_PHASE; k++) random_op();

    // zero and values above the maximum exercise the side clamp
    side_plan = '{1, 0, 31, 7, 17, 2, 16};
    side_plan = {side_plan, int'($urandom_range(0, 31))};
    foreach (side_plan[p]) begin
      set_side(side_plan[p]);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) random_op();
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES + 4) @(posedge clk);

    $display("sent %0d operations across %0d side settings", ops_sent, phases);
    $display("compared %0d read results, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("[digit_matrix_permute_engine_core] OK");
    end else begin
      $display("[digit_matrix_permute_engine_core] ERROR");
    end
    $finish;
  end

endmodule
